// File: rtl/zspfd_pkg.sv
// ----------------------------------------------------------------------------
// zspfd_pkg
// Shared types, codes and constants of the zero-suppressed pixel frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package zspfd_pkg;

  localparam int PIVOT_OFFSET_DEF = 64;
  localparam int MAX_BOARDS_DEF   = 8;

  localparam int WORD_W  = 32;
  localparam int HALF_W  = 16;
  localparam int COL_W   = 12;
  localparam int SCOL_W  = 11;
  localparam int ROW_W   = 11;
  localparam int PIV_W   = 10;
  localparam int TRIG_W  = 16;
  localparam int BOARD_W = 3;
  localparam int STATE_W = 4;
  localparam int LEN_W   = 16;
  localparam int REM_W   = 17;
  localparam int KIND_W  = 2;
  localparam int RUN_W   = 3;

  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 48;
  localparam int M_TUSER_W = 2;

  // ((x mod 9216) / 16) == (x >> 4) mod 576; quotient of (x >> 4) / 576
  // taken as ((x >> 10) * 57) >> 9, exact for the input range here
  localparam int PIV_SUM_W = 17;
  localparam int PIV_Q_W   = 4;
  localparam logic [5:0]  PIV_RECIP = 6'd57;
  localparam int          PIV_SHIFT = 9;
  localparam logic [12:0] ROW_MOD   = 13'd576;

  localparam logic [KIND_W-1:0] KIND_HIT     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TRUNC   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BADLINE = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_WORD1  = 3'd1,
    PH_COUNT  = 3'd2,
    PH_LENGTH = 3'd3,
    PH_DATA   = 3'd4,
    PH_TRAIL1 = 3'd5,
    PH_TRAIL2 = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_RUN  = 2'd1,
    EV_BAD  = 2'd2
  } ev_e;

  // line decoding state carried from one half-word to the next
  typedef struct packed {
    logic               dead;
    logic [STATE_W-1:0] states;
    logic [ROW_W-1:0]   row;
  } line_st_t;

  // what one half-word yields: a run of hits, a bad line, or nothing
  typedef struct packed {
    ev_e               kind;
    logic [SCOL_W-1:0] col;
    logic [1:0]        num;
    logic [ROW_W-1:0]  row;
    logic              ap;
  } half_ev_t;

  typedef struct packed {
    half_ev_t           h0;
    half_ev_t           h1;
    logic               trunc;
    logic               frame;
    logic [BOARD_W-1:0] board;
    logic [TRIG_W-1:0]  trig;
    logic               mism;
  } bundle_t;

  function automatic logic [RUN_W-1:0] ev_count(input half_ev_t ev);
    logic [RUN_W-1:0] c;
    case (ev.kind)
      EV_RUN:  c = {1'b0, ev.num} + RUN_W'(1);
      EV_BAD:  c = RUN_W'(1);
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/zspfd_half.sv
// ----------------------------------------------------------------------------
// zspfd_half
// Decodes one 16-bit half of a data word: line header or state word.
// ----------------------------------------------------------------------------
`default_nettype none

module zspfd_half (
  input  wire logic [zspfd_pkg::HALF_W-1:0] half_i,
  input  wire logic [zspfd_pkg::REM_W-1:0]  remaining_i,
  input  wire logic [zspfd_pkg::PIV_W-1:0]  pivot_row_i,
  input  zspfd_pkg::line_st_t               st_i,
  output zspfd_pkg::line_st_t               st_o,
  output zspfd_pkg::half_ev_t               ev_o
);

  logic [zspfd_pkg::STATE_W-1:0] ns;
  logic [zspfd_pkg::ROW_W-1:0]   hdr_row;
  logic [zspfd_pkg::REM_W-1:0]   need;

  assign ns      = half_i[3:0];
  assign hdr_row = half_i[14:4];
  assign need    = zspfd_pkg::REM_W'(ns) + zspfd_pkg::REM_W'(1);

  always_comb begin
    st_o      = st_i;
    ev_o      = '0;
    ev_o.kind = zspfd_pkg::EV_NONE;
    if (!st_i.dead) begin
      if (st_i.states != '0) begin
        ev_o.kind   = zspfd_pkg::EV_RUN;
        ev_o.col    = half_i[12:2];
        ev_o.num    = half_i[1:0];
        ev_o.row    = st_i.row;
        ev_o.ap     = (st_i.row >= zspfd_pkg::ROW_W'(pivot_row_i));
        st_o.states = st_i.states - zspfd_pkg::STATE_W'(1);
      end else if (remaining_i <= zspfd_pkg::REM_W'(1)) begin
        // last half of the frame never opens a line
        st_o.dead = 1'b1;
      end else if (need > remaining_i) begin
        st_o.dead = 1'b1;
        ev_o.kind = zspfd_pkg::EV_BAD;
        ev_o.row  = hdr_row;
      end else begin
        st_o.states = ns;
        st_o.row    = hdr_row;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/zspfd_out.sv
// ----------------------------------------------------------------------------
// zspfd_out
// Result stage: one staging slot plus an expander that emits one result
// item per cycle from the current bundle while m_axis_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module zspfd_out (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push_i,
  input  zspfd_pkg::bundle_t                   bundle_i,
  output logic                                 ready_o,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // tdata: column[11:0], row[22:12], after_pivot[23], frame_out[24],
  //        board[27:25], trigger[43:28], length_mismatch[44], zero pad
  output logic [zspfd_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  output logic                                 m_axis_tlast,
  // tuser: kind[1:0]
  output logic [zspfd_pkg::M_TUSER_W-1:0]      m_axis_tuser
);

  localparam int RW = zspfd_pkg::RUN_W;

  zspfd_pkg::bundle_t stg_q, cur_q;
  logic               stg_v_q;
  logic [RW-1:0]      rem0_q, rem0_d, rem1_q, rem1_d;
  logic               rem2_q, rem2_d;
  logic               cur_v, last, pop, exp_free, take;
  logic [RW:0]        total;
  logic [RW-1:0]      j;
  logic [zspfd_pkg::KIND_W-1:0] kind;
  logic [zspfd_pkg::COL_W-1:0]  col;
  logic [zspfd_pkg::ROW_W-1:0]  row;
  logic                         ap;

  assign total    = (RW+1)'(rem0_q) + (RW+1)'(rem1_q) + (RW+1)'(rem2_q);
  assign cur_v    = (total != '0);
  assign last     = (total == (RW+1)'(1));
  assign pop      = cur_v && m_axis_tready;
  assign exp_free = !cur_v || (pop && last);
  assign take     = stg_v_q && exp_free;
  assign ready_o  = !stg_v_q || exp_free;

  always_comb begin
    rem0_d = rem0_q;
    rem1_d = rem1_q;
    rem2_d = rem2_q;
    if (take) begin
      rem0_d = zspfd_pkg::ev_count(stg_q.h0);
      rem1_d = zspfd_pkg::ev_count(stg_q.h1);
      rem2_d = stg_q.trunc;
    end else if (pop) begin
      if (rem0_q != '0) begin
        rem0_d = rem0_q - RW'(1);
      end else if (rem1_q != '0) begin
        rem1_d = rem1_q - RW'(1);
      end else begin
        rem2_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= 1'b0;
      rem0_q  <= '0;
      rem1_q  <= '0;
      rem2_q  <= 1'b0;
    end else begin
      if (push_i) begin
        stg_v_q <= 1'b1;
      end else if (take) begin
        stg_v_q <= 1'b0;
      end
      rem0_q <= rem0_d;
      rem1_q <= rem1_d;
      rem2_q <= rem2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cur_q <= stg_q;
    end
    if (push_i) begin
      stg_q <= bundle_i;
    end
  end

  // pick the slot in progress; j is the offset within a run
  always_comb begin
    kind = zspfd_pkg::KIND_TRUNC;
    col  = '0;
    row  = '0;
    ap   = 1'b0;
    j    = '0;
    if (rem0_q != '0) begin
      j    = zspfd_pkg::ev_count(cur_q.h0) - rem0_q;
      kind = (cur_q.h0.kind == zspfd_pkg::EV_RUN) ? zspfd_pkg::KIND_HIT
                                                  : zspfd_pkg::KIND_BADLINE;
      col  = zspfd_pkg::COL_W'(cur_q.h0.col) + zspfd_pkg::COL_W'(j);
      row  = cur_q.h0.row;
      ap   = cur_q.h0.ap;
    end else if (rem1_q != '0) begin
      j    = zspfd_pkg::ev_count(cur_q.h1) - rem1_q;
      kind = (cur_q.h1.kind == zspfd_pkg::EV_RUN) ? zspfd_pkg::KIND_HIT
                                                  : zspfd_pkg::KIND_BADLINE;
      col  = zspfd_pkg::COL_W'(cur_q.h1.col) + zspfd_pkg::COL_W'(j);
      row  = cur_q.h1.row;
      ap   = cur_q.h1.ap;
    end
  end

  assign m_axis_tvalid = cur_v;
  assign m_axis_tlast  = last;
  assign m_axis_tuser  = kind;
  assign m_axis_tdata  = {3'b000, cur_q.mism, cur_q.trig, cur_q.board, cur_q.frame,
                          ap, row, col};

endmodule

`default_nettype wire

// File: rtl/zero_suppressed_pixel_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// zero_suppressed_pixel_frame_decoder_unit
// Parses readout blocks of zero-suppressed pixel data and emits hit items.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                 | tuser          | tlast
//  s_axis   | in  | readout word [31:0]   | first, frame   | final word of block
//  m_axis   | out | hit fields (45 bits)  | kind           | last item of word
//
//  Each accepted word is decoded in the accept cycle; its results move as one
//  bundle into a staging slot, then an expander emits one item per cycle
//  while m_axis_tready is high. A word yields 0..9 results.
//  Reset clears the phase and all control state; a new word can be taken
//  while results of earlier words still wait on a stalled m_axis.
// ----------------------------------------------------------------------------
`default_nettype none

module zero_suppressed_pixel_frame_decoder_unit #(
  parameter int PIVOT_OFFSET = zspfd_pkg::PIVOT_OFFSET_DEF,
  parameter int MAX_BOARDS   = zspfd_pkg::MAX_BOARDS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: word[31:0]
  input  wire logic [zspfd_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  input  wire logic                              s_axis_tlast,
  // tuser: first[0], frame[1]
  input  wire logic [zspfd_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // tdata: column[11:0], row[22:12], after_pivot[23], frame_out[24],
  //        board[27:25], trigger[43:28], length_mismatch[44], zero pad
  output logic [zspfd_pkg::M_TDATA_W-1:0]        m_axis_tdata,
  output logic                                   m_axis_tlast,
  // tuser: kind[1:0]
  output logic [zspfd_pkg::M_TUSER_W-1:0]        m_axis_tuser
);

  localparam int BC_W  = $clog2(MAX_BOARDS + 1);
  localparam int BRD_W = (BC_W > zspfd_pkg::BOARD_W) ? BC_W : zspfd_pkg::BOARD_W;

  zspfd_pkg::phase_e phase_q, phase_d, phase_step;
  logic [zspfd_pkg::PIV_W-1:0]   pivot_q, pivot_d;
  logic [zspfd_pkg::TRIG_W-1:0]  trig_q, trig_d;
  logic [BRD_W-1:0]              board_q, board_d, board_inc;
  logic [zspfd_pkg::LEN_W-1:0]   wl_q, wl_d, wl_dec, len_lo, len_hi;
  logic                          mism_q, mism_d;
  zspfd_pkg::line_st_t           st_q, st_d, st_h0, st_h1;
  zspfd_pkg::half_ev_t           ev_h0, ev_h1;
  zspfd_pkg::bundle_t            bundle;

  logic                          acc, first, fin, fr, data_step, active, ok, trunc, push;
  logic [zspfd_pkg::REM_W-1:0]   rem0, rem1;
  logic [zspfd_pkg::PIV_SUM_W-1:0] piv_sum;
  logic [12:0]                   piv_v, piv_r;
  logic [6:0]                    piv_t;
  logic [12:0]                   piv_prod;
  logic [zspfd_pkg::PIV_Q_W-1:0] piv_q;
  logic                          out_ready;

  assign first = s_axis_tuser[0];
  assign fr    = s_axis_tuser[1];
  assign fin   = s_axis_tlast;
  assign acc   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = out_ready;

  assign len_lo    = s_axis_tdata[15:0];
  assign len_hi    = s_axis_tdata[31:16];
  assign wl_dec    = wl_q - zspfd_pkg::LEN_W'(1);
  assign board_inc = board_q + BRD_W'(1);
  assign data_step = !first && (phase_q == zspfd_pkg::PH_DATA);

  // pivot row = ((pivot + offset) mod 9216) / 16
  assign piv_sum  = zspfd_pkg::PIV_SUM_W'(s_axis_tdata[15:0])
                  + zspfd_pkg::PIV_SUM_W'(PIVOT_OFFSET);
  assign piv_v    = piv_sum[16:4];
  assign piv_t    = piv_v[12:6];
  assign piv_prod = 13'(piv_t) * 13'(zspfd_pkg::PIV_RECIP);
  assign piv_q    = piv_prod[12:zspfd_pkg::PIV_SHIFT];
  assign piv_r    = piv_v - 13'(13'(piv_q) * zspfd_pkg::ROW_MOD);

  assign rem0 = {wl_q, 1'b0};
  assign rem1 = {wl_q, 1'b0} - zspfd_pkg::REM_W'(1);

  zspfd_half u_half0 (
    .half_i      (s_axis_tdata[15:0]),
    .remaining_i (rem0),
    .pivot_row_i (pivot_q),
    .st_i        (st_q),
    .st_o        (st_h0),
    .ev_o        (ev_h0)
  );

  zspfd_half u_half1 (
    .half_i      (s_axis_tdata[31:16]),
    .remaining_i (rem1),
    .pivot_row_i (pivot_q),
    .st_i        (st_h0),
    .st_o        (st_h1),
    .ev_o        (ev_h1)
  );

  // phase sequencing
  always_comb begin
    phase_step = phase_q;
    if (first) begin
      phase_step = zspfd_pkg::PH_WORD1;
    end else begin
      case (phase_q)
        zspfd_pkg::PH_WORD1:  phase_step = zspfd_pkg::PH_COUNT;
        zspfd_pkg::PH_COUNT:  phase_step = zspfd_pkg::PH_LENGTH;
        zspfd_pkg::PH_LENGTH: begin
          phase_step = ((len_lo > len_hi ? len_lo : len_hi) == '0) ?
                       zspfd_pkg::PH_TRAIL1 : zspfd_pkg::PH_DATA;
        end
        zspfd_pkg::PH_DATA: begin
          phase_step = (wl_dec == '0) ? zspfd_pkg::PH_TRAIL1 : zspfd_pkg::PH_DATA;
        end
        zspfd_pkg::PH_TRAIL1: phase_step = zspfd_pkg::PH_TRAIL2;
        zspfd_pkg::PH_TRAIL2: begin
          phase_step = (board_inc >= BRD_W'(MAX_BOARDS)) ?
                       zspfd_pkg::PH_IDLE : zspfd_pkg::PH_COUNT;
        end
        default: phase_step = phase_q;
      endcase
    end
    phase_d = phase_q;
    if (acc) begin
      phase_d = fin ? zspfd_pkg::PH_IDLE : phase_step;
    end
  end

  // block end checks: a final word is fine only as one of the two trailer words
  always_comb begin
    active = first || (phase_q != zspfd_pkg::PH_IDLE);
    ok     = (phase_step == zspfd_pkg::PH_TRAIL2) ||
             (!first && (phase_q == zspfd_pkg::PH_TRAIL2));
    trunc  = fin && active && !ok;
  end

  // datapath state
  always_comb begin
    pivot_d = pivot_q;
    trig_d  = trig_q;
    board_d = board_q;
    wl_d    = wl_q;
    mism_d  = mism_q;
    st_d    = st_q;
    if (first) begin
      board_d   = '0;
      wl_d      = '0;
      mism_d    = 1'b0;
      st_d.dead = 1'b0;
      st_d.states = '0;
    end else begin
      case (phase_q)
        zspfd_pkg::PH_WORD1: begin
          if (!fr) begin
            trig_d  = s_axis_tdata[31:16];
            pivot_d = piv_r[zspfd_pkg::PIV_W-1:0];
          end
        end
        zspfd_pkg::PH_LENGTH: begin
          mism_d      = (len_lo != len_hi);
          wl_d        = (len_lo > len_hi) ? len_lo : len_hi;
          st_d.states = '0;
          st_d.dead   = 1'b0;
        end
        zspfd_pkg::PH_DATA: begin
          st_d = st_h1;
          wl_d = wl_dec;
        end
        zspfd_pkg::PH_TRAIL2: board_d = board_inc;
        default: ;
      endcase
    end
  end

  always_comb begin
    bundle       = '0;
    bundle.h0    = ev_h0;
    bundle.h1    = ev_h1;
    if (!data_step) begin
      bundle.h0.kind = zspfd_pkg::EV_NONE;
      bundle.h1.kind = zspfd_pkg::EV_NONE;
    end
    bundle.trunc = trunc;
    bundle.frame = fr;
    bundle.board = board_d[zspfd_pkg::BOARD_W-1:0];
    bundle.trig  = trig_d;
    bundle.mism  = mism_d;
  end

  assign push = acc && ((bundle.h0.kind != zspfd_pkg::EV_NONE) ||
                        (bundle.h1.kind != zspfd_pkg::EV_NONE) || bundle.trunc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= zspfd_pkg::PH_IDLE;
      pivot_q <= '0;
      trig_q  <= '0;
      board_q <= '0;
      wl_q    <= '0;
      mism_q  <= 1'b0;
      st_q    <= '0;
    end else begin
      phase_q <= phase_d;
      if (acc) begin
        pivot_q <= pivot_d;
        trig_q  <= trig_d;
        board_q <= board_d;
        wl_q    <= wl_d;
        mism_q  <= mism_d;
        st_q    <= st_d;
      end
    end
  end

  zspfd_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .bundle_i      (bundle),
    .ready_o       (out_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // a data phase always has words left to read
  a_data_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == zspfd_pkg::PH_DATA) |-> (wl_q != '0))
    else $error("data phase with no words left");

  a_board_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    board_q <= BRD_W'(MAX_BOARDS))
    else $error("board index past limit");

  a_kind_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser != 2'd3))
    else $error("undefined result kind");

  // a truncation is the last item of its word
  a_trunc_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == zspfd_pkg::KIND_TRUNC)) |-> m_axis_tlast)
    else $error("truncation item not last");

endmodule

`default_nettype wire
